// File: rtl/core/iira_pkg.sv
// Shared types and constants for the indexed insert/remove array.
`default_nettype none
package iira_pkg;

  // Store geometry
  localparam int CAPACITY   = 256;
  localparam int WORD_WIDTH = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Port field widths
  localparam int MODE_W = 3;
  localparam int POS_W  = 9;
  localparam int VAL_W  = 64;
  localparam int LEN_W  = 9;
  localparam int STAT_W = 2;

  // Common width for position against count compares
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND  = 3'd0,
    MODE_INSERT  = 3'd1,
    MODE_READ    = 3'd2,
    MODE_REMOVE  = 3'd3,
    MODE_REPLACE = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Request to the element memory
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [WORD_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
  } ram_req_t;

  // Finished result of one request
  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] length;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/iira_ram.sv
// Element memory: one write and one registered read per cycle.
`default_nettype none
module iira_ram (
  input  wire logic                           clk_i,
  input  wire iira_pkg::ram_req_t             req_i,
  output logic [iira_pkg::WORD_WIDTH-1:0]     rdata_o
);
  import iira_pkg::*;

  logic [WORD_WIDTH-1:0] mem [CAPACITY];
  logic [WORD_WIDTH-1:0] rdata_q;

  // Write the requested entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/core/iira_ctrl.sv
// Request sequencer: range checks, shift loop and count keeping.
`default_nettype none
module iira_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [iira_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [iira_pkg::POS_W-1:0]      position_i,
  input  wire logic [iira_pkg::VAL_W-1:0]      new_value_i,
  output logic                                 res_valid_o,
  input  wire logic                            res_stall_i,
  output iira_pkg::res_t                       res_o,
  output iira_pkg::ram_req_t                   ram_req_o,
  input  wire logic [iira_pkg::WORD_WIDTH-1:0] ram_rdata_i
);
  import iira_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_RDWAIT,
    S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  mode_e                 mode_q, mode_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [WORD_WIDTH-1:0] word_q, word_d;
  logic [IDX_W-1:0]      ptr_q, ptr_d;
  logic [IDX_W-1:0]      end_q, end_d;
  logic                  pend_q, pend_d;
  logic [IDX_W-1:0]      pend_addr_q, pend_addr_d;
  status_e               status_q, status_d;
  logic [VAL_W-1:0]      rdval_q, rdval_d;

  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [IDX_W-1:0] pos_idx;
  logic             full;
  logic             is_ins;

  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(pos_q);
  assign pos_idx = IDX_W'(pos_ext);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign is_ins  = (mode_q == MODE_INSERT);

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o.status     = status_q;
  assign res_o.read_value = rdval_q;
  assign res_o.length     = LEN_W'(count_q);

  // Sequence one request at a time
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    mode_d      = mode_q;
    pos_d       = pos_q;
    word_d      = word_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    status_d    = status_q;
    rdval_d     = rdval_q;
    ram_req_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_e'(mode_i);
          pos_d    = position_i;
          word_d   = WORD_WIDTH'(new_value_i);
          status_d = ST_DONE;
          rdval_d  = '0;
          pend_d   = 1'b0;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_RESP;
        case (mode_q)
          MODE_APPEND: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = IDX_W'(cnt_ext);
              ram_req_o.wdata = word_q;
              count_d         = count_q + 1'b1;
            end
          end
          MODE_INSERT: begin
            if (pos_ext > cnt_ext) begin
              status_d = ST_RANGE;
            end else if (full) begin
              status_d = ST_FULL;
            end else if (pos_ext == cnt_ext) begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = pos_idx;
              ram_req_o.wdata = word_q;
              count_d         = count_q + 1'b1;
            end else begin
              // move entries up, from the top down to the position
              ptr_d   = IDX_W'(cnt_ext - 1'b1);
              end_d   = pos_idx;
              state_d = S_SHIFT;
            end
          end
          MODE_READ: begin
            if (pos_ext >= cnt_ext) begin
              status_d = ST_RANGE;
            end else begin
              ram_req_o.raddr = pos_idx;
              state_d         = S_RDWAIT;
            end
          end
          MODE_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
              status_d = ST_RANGE;
            end else if (pos_ext == cnt_ext - 1'b1) begin
              count_d = count_q - 1'b1;
            end else begin
              // move entries down, from just above the position to the top
              ptr_d   = pos_idx + 1'b1;
              end_d   = IDX_W'(cnt_ext - 1'b1);
              state_d = S_SHIFT;
            end
          end
          MODE_REPLACE: begin
            if (pos_ext >= cnt_ext) begin
              status_d = ST_RANGE;
            end else begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = pos_idx;
              ram_req_o.wdata = word_q;
            end
          end
          default: begin
            status_d = ST_DONE;
          end
        endcase
      end

      S_SHIFT: begin
        // read one entry, write back the one read last cycle
        ram_req_o.raddr = ptr_q;
        if (pend_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = pend_addr_q;
          ram_req_o.wdata = ram_rdata_i;
        end
        pend_d      = 1'b1;
        pend_addr_d = is_ins ? (ptr_q + 1'b1) : (ptr_q - 1'b1);
        if (ptr_q == end_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = is_ins ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
        end
      end

      S_DRAIN: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = pend_addr_q;
        ram_req_o.wdata = ram_rdata_i;
        pend_d          = 1'b0;
        if (is_ins) begin
          state_d = S_PUT;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_RESP;
        end
      end

      S_PUT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = pos_idx;
        ram_req_o.wdata = word_q;
        count_d         = count_q + 1'b1;
        state_d         = S_RESP;
      end

      S_RDWAIT: begin
        rdval_d = VAL_W'(ram_rdata_i);
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!res_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, count and pending write-back flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    pos_q       <= pos_d;
    word_q      <= word_d;
    ptr_q       <= ptr_d;
    end_q       <= end_d;
    pend_addr_q <= pend_addr_d;
    status_q    <= status_d;
    rdval_q     <= rdval_d;
  end

endmodule
`default_nettype wire

// File: rtl/core/indexed_insert_remove_array_top.sv
// Top level of the indexed insert/remove array with its output register.
//
//   channel | direction | handshake                 | beat fields
//   --------+-----------+---------------------------+------------------------------
//   in      | into      | in_valid_i / in_stall_o   | mode_i, position_i, new_value_i
//   out     | out of    | out_valid_o / out_stall_i | status_o, read_value_o, length_o
//
// Append, replace, insert at the end, removal of the last entry, refused requests and
// unknown modes finish in the execute state; a read also waits for the registered memory
// word. Other inserts and removals move entries one at a time through the shift and drain
// states, as the element memory has a single read and write port pair.
// Reset clears the length and control state; the memory itself needs no clearing pass.
// A stalled result waits in the output register while the next beat is taken in.
`default_nettype none
module indexed_insert_remove_array_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [iira_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [iira_pkg::POS_W-1:0]    position_i,
  input  wire logic [iira_pkg::VAL_W-1:0]    new_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [iira_pkg::STAT_W-1:0]        status_o,
  output logic [iira_pkg::VAL_W-1:0]         read_value_o,
  output logic [iira_pkg::LEN_W-1:0]         length_o
);
  import iira_pkg::*;

  ram_req_t              ram_req;
  logic [WORD_WIDTH-1:0] ram_rdata;
  logic                  res_valid;
  logic                  res_stall;
  res_t                  res;

  logic                  out_valid_q;
  res_t                  out_q;

  iira_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .position_i  (position_i),
    .new_value_i (new_value_i),
    .res_valid_o (res_valid),
    .res_stall_i (res_stall),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  iira_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Take a result only when the output register is free or being emptied
  assign res_stall = out_valid_q && out_stall_i;

  // Output valid: load a new beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && !res_stall) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (res_valid && !res_stall) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign read_value_o = out_q.read_value;
  assign length_o     = out_q.length;

  // Length never passes the capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (length_o <= LEN_W'(CAPACITY)))
    else $error("length beyond capacity");

  // A full refusal only happens at capacity
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (length_o == LEN_W'(CAPACITY)))
    else $error("store full reported below capacity");

  // A refused request returns no word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DONE)) |-> (read_value_o == '0))
    else $error("word returned with an error status");

  // After a beat is taken the sequencer is busy with it
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("new beat taken while one is in work");

endmodule
`default_nettype wire
